/* src/least_resistance_optical_depth_defines.svh */
// ----------------------------------------------------------------------------
// least_resistance_optical_depth_defines
// assertion macros shared by the optical depth block
// ----------------------------------------------------------------------------
`ifndef LEAST_RESISTANCE_OPTICAL_DEPTH_DEFINES_SVH
`define LEAST_RESISTANCE_OPTICAL_DEPTH_DEFINES_SVH

// same-cycle implication
`define LROD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LROD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lrod_pkg.sv */
// ----------------------------------------------------------------------------
// lrod_pkg
// types and constants of the optical depth block
// ----------------------------------------------------------------------------
package lrod_pkg;

  localparam int unsigned FIELD_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned AXIS_BITS    = 2;
  localparam int unsigned MUL_DIGIT    = 8;

  localparam logic [FIELD_BITS-1:0] SPACING_RESET = 32'h0001_0000;

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL_DS,
    ST_MUL_P,
    ST_SUM
  } lrod_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lrod_unit_sts_t;

endpackage

/* src/lrod_root.sv */
// ----------------------------------------------------------------------------
// lrod_root
// bit-serial fixed point square root, one root bit per cycle
// ----------------------------------------------------------------------------
module lrod_root import lrod_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ROOT_BITS  = (VALUE_BITS + FRAC_BITS + 1) / 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output lrod_unit_sts_t        sts_o,
  output logic [ROOT_BITS-1:0]  root_o
);

  localparam int unsigned XW   = 2 * ROOT_BITS;
  localparam int unsigned REMW = ROOT_BITS + 3;
  localparam int unsigned CW   = $clog2(ROOT_BITS + 1);

  logic [XW-1:0]        x_q, x_d;
  logic [REMW-1:0]      rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;

  assign rem_sh = {rem_q[REMW-3:0], x_q[XW-1:XW-2]};
  assign trial  = REMW'({root_q, 2'b01});

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = XW'({value_i, {FRAC_BITS{1'b0}}});
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(ROOT_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d   = {x_q[XW-3:0], 2'b00};
      cnt_d = cnt_q - CW'(1);
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

/* src/lrod_qmul.sv */
// ----------------------------------------------------------------------------
// lrod_qmul
// shared fixed point multiplier, one 8-bit digit of b per cycle, saturating
// ----------------------------------------------------------------------------
module lrod_qmul import lrod_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned OP_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [OP_BITS-1:0]    a_i,
  input  logic [OP_BITS-1:0]    b_i,
  output lrod_unit_sts_t        sts_o,
  output logic [VALUE_BITS-1:0] res_o,
  output logic                  clip_o
);

  localparam int unsigned ND   = (OP_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned BPW  = ND * MUL_DIGIT;
  localparam int unsigned PW   = OP_BITS + BPW;
  localparam int unsigned QW   = VALUE_BITS + FRAC_BITS;
  localparam int unsigned ACCW = ((PW > QW) ? PW : QW) + 1;
  localparam int unsigned PRW  = OP_BITS + MUL_DIGIT;
  localparam int unsigned CW   = $clog2(ND + 1);

  logic [OP_BITS-1:0] a_q, a_d;
  logic [BPW-1:0]     b_q, b_d;
  logic [ACCW-1:0]    acc_q, acc_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [PRW-1:0] prod;

  assign prod = PRW'(a_q) * PRW'(b_q[BPW-1 -: MUL_DIGIT]);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = BPW'(b_i);
      acc_d  = '0;
      cnt_d  = CW'(ND);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[ACCW-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + ACCW'(prod);
      b_d   = {b_q[BPW-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign clip_o     = |acc_q[ACCW-1:QW];
  assign res_o      = clip_o ? {VALUE_BITS{1'b1}} : acc_q[QW-1:FRAC_BITS];
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

/* src/least_resistance_optical_depth.sv */
// one neighbor word is accepted when idle; its candidate is formed after R root
// steps, R = (VALUE_BITS+FRAC_BITS+1)/2, and two passes of D = ceil(M/8)
// digits through the shared multiplier, M = max(VALUE_BITS, R)
// no new word is taken until the root unit, both multiplier passes and the sum
// state are done; a last word also waits in the sum state for a free output
// reset: spacing 1.0 on all axes, running minimum all ones, no clip, no output
// ----------------------------------------------------------------------------
// least_resistance_optical_depth
// running minimum of neighbor depth plus path length times face opacity
// ----------------------------------------------------------------------------
`include "least_resistance_optical_depth_defines.svh"

module least_resistance_optical_depth import lrod_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [FIELD_BITS-1:0]   cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // metric_center, metric_neighbor, opacity_center, opacity_neighbor,
  // depth_neighbor
  input  logic [5*FIELD_BITS-1:0] s_axis_tdata,
  // axis
  input  logic [AXIS_BITS-1:0]    s_axis_tuser,
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // min_depth
  output logic [FIELD_BITS-1:0]   m_axis_tdata,
  // saturated
  output logic [0:0]              m_axis_tuser
);

  localparam int unsigned ROOT_BITS = (VALUE_BITS + FRAC_BITS + 1) / 2;
  localparam int unsigned OP_BITS   = (VALUE_BITS > ROOT_BITS) ? VALUE_BITS : ROOT_BITS;
  localparam logic [VALUE_BITS-1:0] MAXV = {VALUE_BITS{1'b1}};

  function automatic logic [VALUE_BITS-1:0] to_val(input logic [FIELD_BITS-1:0] f);
    logic [VALUE_BITS+FIELD_BITS-1:0] ext;
    ext = {{VALUE_BITS{1'b0}}, f};
    return ext[VALUE_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS+FIELD_BITS-1:0] ext;
    ext = {{FIELD_BITS{1'b0}}, v};
    return ext[FIELD_BITS-1:0];
  endfunction

  lrod_state_e state_q, state_d;

  logic [FIELD_BITS-1:0] spc_x_q, spc_y_q, spc_z_q;
  logic [VALUE_BITS-1:0] spacing_q, spacing_d;
  logic [VALUE_BITS-1:0] kface_q, kface_d;
  logic [VALUE_BITS-1:0] dn_q, dn_d;
  logic [VALUE_BITS-1:0] p_q, p_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] running_min_q, running_min_d;
  logic                  clip_q, clip_d;
  logic                  m_valid_q, m_valid_d;
  logic [FIELD_BITS-1:0] m_data_q, m_data_d;
  logic                  m_user_q, m_user_d;

  logic                  s_acc;
  logic [VALUE_BITS:0]   gsum, ksum;
  logic [VALUE_BITS-1:0] gface;
  logic                  root_start, mul_start;
  lrod_unit_sts_t        root_sts, mul_sts;
  logic [ROOT_BITS-1:0]  root;
  logic [OP_BITS-1:0]    mul_a, mul_b;
  logic [VALUE_BITS-1:0] mul_res;
  logic                  mul_clip;
  logic [VALUE_BITS:0]   cand_sum;
  logic [VALUE_BITS-1:0] cand, new_min;
  logic                  out_free, emit;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign gsum  = (VALUE_BITS+1)'(to_val(s_axis_tdata[0*FIELD_BITS +: FIELD_BITS]))
               + (VALUE_BITS+1)'(to_val(s_axis_tdata[1*FIELD_BITS +: FIELD_BITS]));
  assign ksum  = (VALUE_BITS+1)'(to_val(s_axis_tdata[2*FIELD_BITS +: FIELD_BITS]))
               + (VALUE_BITS+1)'(to_val(s_axis_tdata[3*FIELD_BITS +: FIELD_BITS]));
  assign gface = gsum[VALUE_BITS:1];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_x_q <= SPACING_RESET;
      spc_y_q <= SPACING_RESET;
      spc_z_q <= SPACING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SPACING_X: spc_x_q <= cfg_data_i;
        REG_SPACING_Y: spc_y_q <= cfg_data_i;
        REG_SPACING_Z: spc_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrod_root #(
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ROOT_BITS (ROOT_BITS)
  ) u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .value_i(gface),
    .sts_o  (root_sts),
    .root_o (root)
  );

  assign mul_a = (state_q == ST_ROOT) ? OP_BITS'(spacing_q) : OP_BITS'(mul_res);
  assign mul_b = (state_q == ST_ROOT) ? OP_BITS'(root) : OP_BITS'(kface_q);

  lrod_qmul #(
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS (FRAC_BITS),
    .OP_BITS   (OP_BITS)
  ) u_qmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .sts_o  (mul_sts),
    .res_o  (mul_res),
    .clip_o (mul_clip)
  );

  assign cand_sum = (VALUE_BITS+1)'(dn_q) + (VALUE_BITS+1)'(p_q);
  assign cand     = cand_sum[VALUE_BITS] ? MAXV : cand_sum[VALUE_BITS-1:0];
  assign new_min  = (cand < running_min_q) ? cand : running_min_q;
  assign out_free = !m_valid_q || m_axis_tready;
  assign emit     = (state_q == ST_SUM) && last_q && out_free;

  always_comb begin
    state_d       = state_q;
    spacing_d     = spacing_q;
    kface_d       = kface_q;
    dn_d          = dn_q;
    p_d           = p_q;
    last_d        = last_q;
    running_min_d = running_min_q;
    clip_d        = clip_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;
    root_start    = 1'b0;
    mul_start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          root_start = 1'b1;
          kface_d    = ksum[VALUE_BITS:1];
          dn_d       = to_val(s_axis_tdata[4*FIELD_BITS +: FIELD_BITS]);
          last_d     = s_axis_tlast;
          unique case (s_axis_tuser)
            AXIS_X:  spacing_d = to_val(spc_x_q);
            AXIS_Y:  spacing_d = to_val(spc_y_q);
            default: spacing_d = to_val(spc_z_q);
          endcase
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_sts.done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL_DS;
        end
      end
      ST_MUL_DS: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          clip_d    = clip_q | mul_clip;
          state_d   = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_sts.done) begin
          p_d     = mul_res;
          clip_d  = clip_q | mul_clip;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!last_q) begin
          running_min_d = new_min;
          clip_d        = clip_q | cand_sum[VALUE_BITS];
          state_d       = ST_IDLE;
        end else if (out_free) begin
          m_valid_d     = 1'b1;
          m_data_d      = to_field(new_min);
          m_user_d      = clip_q | cand_sum[VALUE_BITS];
          running_min_d = MAXV;
          clip_d        = 1'b0;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      running_min_q <= MAXV;
      clip_q        <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      running_min_q <= running_min_d;
      clip_q        <= clip_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spacing_q <= spacing_d;
    kface_q   <= kface_d;
    dn_q      <= dn_d;
    p_q       <= p_d;
    last_q    <= last_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  `LROD_ASSERT_IMPLY(a_out_from_sum, $rose(m_axis_tvalid), $past(state_q) == ST_SUM,
                     "result word without a finished last neighbor")
  `LROD_ASSERT_NEXT(a_min_cleared, emit, running_min_q == MAXV && !clip_q,
                    "cell state not cleared after emit")
  `LROD_ASSERT_IMPLY(a_units_idle, state_q == ST_IDLE, !root_sts.busy && !mul_sts.busy,
                     "arithmetic unit busy while idle")

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the optical depth block: neighbor words go out from
// a queue with random gaps (none in one phase), each accepted word runs
// through a local model of face averages, q root and saturating products, and
// every output word is compared against the oldest predicted cell minimum and
// saturation flag; spacing is rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_top;
  import lrod_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AXIS_BITS-1:0]    AXIS_Z      = 2'd2;
  localparam logic [AXIS_BITS-1:0]    AXIS_SPARE  = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED  = 2'd3;
  localparam logic [FIELD_BITS-1:0]   Q_MAX       = '1;
  localparam logic [FIELD_BITS-1:0]   Q_ONE       = 32'h0001_0000;
  localparam int unsigned             SETTLE_CYC  = 80;
  localparam int unsigned             QUIET_LIMIT = 4000;

  typedef struct {
    logic [AXIS_BITS-1:0]  axis;
    logic [FIELD_BITS-1:0] metric_center;
    logic [FIELD_BITS-1:0] metric_neighbor;
    logic [FIELD_BITS-1:0] opacity_center;
    logic [FIELD_BITS-1:0] opacity_neighbor;
    logic [FIELD_BITS-1:0] depth_neighbor;
    logic                  last_neighbor;
  } neighbor_word_t;

  typedef struct {
    logic [FIELD_BITS-1:0] min_depth;
    logic                  saturated;
  } cell_depth_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i   = '0;
  logic [FIELD_BITS-1:0]   cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // metric_center, metric_neighbor, opacity_center, opacity_neighbor,
  // depth_neighbor
  logic [5*FIELD_BITS-1:0] s_axis_tdata  = '0;
  // axis
  logic [AXIS_BITS-1:0]    s_axis_tuser  = '0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // min_depth
  logic [FIELD_BITS-1:0]   m_axis_tdata;
  // saturated
  logic [0:0]              m_axis_tuser;

  neighbor_word_t pending_words[$];
  cell_depth_t    cell_depths[$];
  neighbor_word_t word_on_bus;

  logic [FIELD_BITS-1:0] spacing_x_mdl = SPACING_RESET;
  logic [FIELD_BITS-1:0] spacing_y_mdl = SPACING_RESET;
  logic [FIELD_BITS-1:0] spacing_z_mdl = SPACING_RESET;
  logic [FIELD_BITS-1:0] cell_min_mdl  = Q_MAX;
  logic                  cell_clip_mdl = 1'b0;

  int unsigned send_gap    = 0;
  int unsigned recv_stall  = 0;
  int unsigned quiet_count = 0;
  int unsigned fail_count  = 0;
  bit          no_idle     = 1'b0;

  least_resistance_optical_depth dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [FIELD_BITS-1:0] face_avg(logic [FIELD_BITS-1:0] a,
                                                     logic [FIELD_BITS-1:0] b);
    return (a >> 1) + (b >> 1) + (a & b & 32'd1);
  endfunction

  function automatic logic [FIELD_BITS-1:0] q_root(logic [FIELD_BITS-1:0] g);
    logic [63:0]           radicand;
    logic [FIELD_BITS-1:0] root;
    logic [FIELD_BITS-1:0] trial;
    radicand = {16'd0, g, 16'd0};
    root = '0;
    for (int b = FIELD_BITS - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic logic [FIELD_BITS-1:0] q_mul_sat(logic [FIELD_BITS-1:0] a,
                                                      logic [FIELD_BITS-1:0] b);
    logic [63:0] prod;
    prod = (64'(a) * 64'(b)) >> 16;
    if (prod > 64'(Q_MAX)) begin
      cell_clip_mdl = 1'b1;
      return Q_MAX;
    end
    return prod[FIELD_BITS-1:0];
  endfunction

  function automatic void absorb_neighbor(neighbor_word_t w);
    logic [FIELD_BITS-1:0] spacing;
    logic [FIELD_BITS-1:0] path_len;
    logic [FIELD_BITS-1:0] path_depth;
    logic [FIELD_BITS:0]   cand_sum;
    logic [FIELD_BITS-1:0] cand;
    cell_depth_t           res;
    case (w.axis)
      AXIS_X:  spacing = spacing_x_mdl;
      AXIS_Y:  spacing = spacing_y_mdl;
      default: spacing = spacing_z_mdl;
    endcase
    path_len   = q_mul_sat(spacing, q_root(face_avg(w.metric_center, w.metric_neighbor)));
    path_depth = q_mul_sat(path_len, face_avg(w.opacity_center, w.opacity_neighbor));
    cand_sum   = 33'(w.depth_neighbor) + 33'(path_depth);
    if (cand_sum > 33'(Q_MAX)) begin
      cell_clip_mdl = 1'b1;
      cand = Q_MAX;
    end else begin
      cand = cand_sum[FIELD_BITS-1:0];
    end
    if (cand < cell_min_mdl) cell_min_mdl = cand;
    if (w.last_neighbor) begin
      res.min_depth = cell_min_mdl;
      res.saturated = cell_clip_mdl;
      cell_depths.push_back(res);
      cell_min_mdl  = Q_MAX;
      cell_clip_mdl = 1'b0;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_q(logic [FIELD_BITS-1:0] span);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    case (roll)
      0:       return '0;
      1:       return Q_MAX;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, span);
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) absorb_neighbor(word_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          s_axis_tdata  <= {word_on_bus.depth_neighbor, word_on_bus.opacity_neighbor,
                            word_on_bus.opacity_center, word_on_bus.metric_neighbor,
                            word_on_bus.metric_center};
          s_axis_tuser  <= word_on_bus.axis;
          s_axis_tlast  <= word_on_bus.last_neighbor;
          s_axis_tvalid <= 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    cell_depth_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_depths.size() == 0) begin
          $error("unexpected word: min_depth %h saturated %b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = cell_depths.pop_front();
          if (m_axis_tdata !== want.min_depth) begin
            $error("min_depth: expected %h, actual %h", want.min_depth, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) recv_stall = pick_gap();
      end
    end
  end

  // cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
  end

  initial begin
    while (quiet_count < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  task automatic push_word(logic [AXIS_BITS-1:0] axis, logic [FIELD_BITS-1:0] mc,
                           logic [FIELD_BITS-1:0] mn, logic [FIELD_BITS-1:0] kc,
                           logic [FIELD_BITS-1:0] kn, logic [FIELD_BITS-1:0] dn,
                           logic last);
    neighbor_word_t w;
    w.axis             = axis;
    w.metric_center    = mc;
    w.metric_neighbor  = mn;
    w.opacity_center   = kc;
    w.opacity_neighbor = kn;
    w.depth_neighbor   = dn;
    w.last_neighbor    = last;
    pending_words.push_back(w);
  endtask

  task automatic write_spacing(logic [CFG_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SPACING_X: spacing_x_mdl = value;
      REG_SPACING_Y: spacing_y_mdl = value;
      REG_SPACING_Z: spacing_z_mdl = value;
      default: ;
    endcase
    // cfg_valid_i is dropped between writes
    @(posedge clk_i);
  endtask

  // waits until the block is empty and settled before the next phase
  task automatic drain_block();
    while (pending_words.size() != 0 || s_axis_tvalid || cell_depths.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic queue_random_cells(int unsigned count, logic [FIELD_BITS-1:0] span);
    int unsigned added;
    int unsigned cell_len;
    bit          broken;
    added = 0;
    while (added < count) begin
      cell_len = $urandom_range(1, 6);
      broken   = ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < cell_len; i++) begin
        push_word(AXIS_BITS'($urandom_range(0, 3)), rand_q(span), rand_q(span),
                  rand_q(span), rand_q(span), rand_q(32'h0100_0000),
                  broken ? 1'($urandom_range(0, 1)) : (i == cell_len - 1));
        added++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells at reset spacing
    push_word(AXIS_X, '0, '0, '0, '0, '0, 1'b1);
    push_word(AXIS_X, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
    push_word(AXIS_X, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'h0005_0000, 1'b0);
    push_word(AXIS_Y, 32'h0004_0000, 32'h0004_0000, Q_ONE, Q_ONE, 32'h0002_0000, 1'b0);
    push_word(AXIS_Z, 32'h0000_4000, 32'h0000_4000, 32'h0003_0000, Q_ONE, Q_ONE, 1'b0);
    push_word(AXIS_SPARE, Q_ONE, 32'h0003_0000, Q_ONE, 32'h0000_8000, 32'h0000_1000, 1'b1);
    push_word(AXIS_X, 32'd1, 32'd1, 32'd3, 32'd1, 32'd7, 1'b1);
    push_word(AXIS_Y, Q_MAX, '0, '0, Q_MAX, '0, 1'b1);
    push_word(AXIS_Z, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_MAX, 1'b0);
    push_word(AXIS_X, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'hFFFF_0000, 1'b1);
    push_word(AXIS_Y, Q_MAX, Q_MAX, 32'h0001_0001, 32'h0001_0001, 32'd5, 1'b1);
    push_word(AXIS_Z, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 1'b1);
    push_word(AXIS_SPARE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 1'b0);
    push_word(AXIS_X, '0, '0, Q_MAX, Q_MAX, 32'd9, 1'b1);
    push_word(AXIS_Y, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);
    drain_block();

    write_spacing(REG_SPACING_X, '0);
    write_spacing(REG_SPACING_Y, Q_MAX);
    write_spacing(REG_SPACING_Z, 32'h0000_8000);
    write_spacing(REG_UNUSED, $urandom());
    push_word(AXIS_Y, Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, 1'b1);
    push_word(AXIS_X, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'd11, 1'b1);
    queue_random_cells(90, 32'h0008_0000);
    drain_block();

    write_spacing(REG_SPACING_X, Q_MAX);
    write_spacing(REG_SPACING_Y, 32'h0002_0000);
    write_spacing(REG_SPACING_Z, '0);
    queue_random_cells(90, 32'h0002_0000);
    drain_block();

    no_idle = 1'b1;
    write_spacing(REG_SPACING_X, $urandom_range(0, 32'h0004_0000));
    write_spacing(REG_SPACING_Y, $urandom_range(0, 32'h0004_0000));
    write_spacing(REG_SPACING_Z, $urandom_range(0, 32'h0004_0000));
    queue_random_cells(90, 32'h0008_0000);
    drain_block();
    no_idle = 1'b0;

    write_spacing(REG_SPACING_X, $urandom());
    write_spacing(REG_SPACING_Y, $urandom());
    write_spacing(REG_SPACING_Z, $urandom());
    write_spacing(REG_UNUSED, $urandom());
    queue_random_cells(90, 32'h0000_4000);
    drain_block();

    write_spacing(REG_SPACING_X, SPACING_RESET);
    write_spacing(REG_SPACING_Y, SPACING_RESET);
    write_spacing(REG_SPACING_Z, SPACING_RESET);
    queue_random_cells(90, 32'h0008_0000);
    // close any open cell so the model and block both end clean
    push_word(AXIS_X, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    drain_block();

    if (cell_depths.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lrod_pkg.sv
src/lrod_root.sv
src/lrod_qmul.sv
src/least_resistance_optical_depth.sv
test/tb_top.sv
